@@ rtl/core/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared constants and types of the sphere/frustum culling block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

	// fixed formats of the camera set
	localparam int AXIS_W    = 16;
	localparam int AXIS_FRAC = 14;
	localparam int TAN_W     = 16;
	localparam int TAN_FRAC  = 12;

	// sqrt(3) in Q1.14
	localparam int SQRT3_W = 15;
	localparam logic [SQRT3_W-1:0] SQRT3_Q14 = 15'd28378;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_CAM_POS  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_AX  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE_AX  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_AX    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FAR      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_X    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TAN_Y    = 4'd7;

	// verdict codes
	localparam int VERDICT_W = 3;
	localparam logic [VERDICT_W-1:0] VERDICT_VISIBLE = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_FAR     = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_NEAR    = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_HORIZ   = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_VERT    = 3'd4;

	localparam int OUT_W = 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sfc_front.sv @@
// ----------------------------------------------------------------------------
// sfc_front
// Accepts spheres, applies the center offset and forms the camera-to-center
// vector; hands a registered item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_front #(
	parameter int COORD_BITS = 20,
	parameter int FRAC_BITS  = 4,
	parameter int IN_W       = 80,
	parameter int ITEM_W     = 85
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [IN_W-1:0]         in_data,
	input  wire logic [3*COORD_BITS-1:0] cam_pos,
	output logic                         item_valid,
	input  wire logic                    item_ready,
	output logic [ITEM_W-1:0]            item_data
);

	localparam int C  = COORD_BITS;
	localparam int VW = C + 2;

	logic                  vld_q;
	logic [ITEM_W-1:0]     item_q;
	logic                  accept;
	logic                  push;
	logic [C-2:0]          r;
	logic                  do_offset;
	logic signed [VW-1:0]  v [3];
	logic signed [VW-1:0]  r_ext;

	assign push     = vld_q & item_ready;
	assign in_ready = ~vld_q | item_ready;
	assign accept   = in_valid & in_ready;

	assign r         = in_data[3*C +: C-1];
	assign do_offset = r >= (C-1)'(1 << FRAC_BITS);
	assign r_ext     = $signed({3'b000, r});

	// center (offset by r when r >= 1.0) minus camera position
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v[k] = $signed({{2{in_data[k*C + C-1]}}, in_data[k*C +: C]})
				+ (do_offset ? r_ext : VW'(0))
				- $signed({{2{cam_pos[(2-k)*C + C-1]}}, cam_pos[(2-k)*C +: C]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= accept | (vld_q & ~push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= {r, v[2], v[1], v[0]};
		end
	end

	assign item_valid = vld_q;
	assign item_data  = item_q;

endmodule

`default_nettype wire

@@ rtl/core/sfc_queue.sv @@
// ----------------------------------------------------------------------------
// sfc_queue
// Small FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_queue #(
	parameter int WIDTH = 85
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data,
	output sfc_pkg::q_stat_t      stat
);

	logic [WIDTH-1:0]          mem_q [sfc_pkg::QUEUE_DEPTH];
	logic [sfc_pkg::QPTR_W-1:0] wr_q;
	logic [sfc_pkg::QPTR_W-1:0] rd_q;
	logic [sfc_pkg::QPTR_W:0]   cnt_q;
	logic                       do_push;
	logic                       do_pop;

	assign stat.full  = cnt_q == (sfc_pkg::QPTR_W+1)'(sfc_pkg::QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;

	assign push_ready = ~stat.full;
	assign pop_valid  = ~stat.empty;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid & ~stat.full;
	assign do_pop     = pop_ready & ~stat.empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop)  rd_q <= rd_q + 1'b1;
			if (do_push & ~do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop & ~do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sfc_back.sv @@
// ----------------------------------------------------------------------------
// sfc_back
// Five-stage test pipeline: axis products, dot sums, near/far tests,
// cone products, cone compares and verdict register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_back #(
	parameter int COORD_BITS = 20,
	parameter int ITEM_W     = 85
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire logic [ITEM_W-1:0]                   item_data,
	input  wire logic [3*sfc_pkg::AXIS_W-1:0]        view_ax,
	input  wire logic [3*sfc_pkg::AXIS_W-1:0]        side_ax,
	input  wire logic [3*sfc_pkg::AXIS_W-1:0]        up_ax,
	input  wire logic [COORD_BITS-2:0]               near_dist,
	input  wire logic [COORD_BITS-2:0]               far_dist,
	input  wire logic [sfc_pkg::TAN_W-1:0]           tan_x,
	input  wire logic [sfc_pkg::TAN_W-1:0]           tan_y,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [sfc_pkg::OUT_W-1:0]                out_data
);

	localparam int C   = COORD_BITS;
	localparam int VW  = C + 2;
	localparam int PW  = VW + sfc_pkg::AXIS_W;
	localparam int DW  = PW + 2;
	localparam int EW  = C - 1 + sfc_pkg::SQRT3_W;
	localparam int FEW = EW + 1;
	localparam int MW  = DW + sfc_pkg::TAN_W;
	localparam int SW  = MW + 1;
	localparam int AF  = sfc_pkg::AXIS_FRAC;
	localparam int TF  = sfc_pkg::TAN_FRAC;

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	// stage 1
	logic signed [VW-1:0]     v [3];
	logic [C-2:0]             r;
	logic signed [sfc_pkg::AXIS_W-1:0] ax [3][3];
	logic signed [PW-1:0]     prod_s1 [3][3];
	logic [EW-1:0]            eff_s1;

	// stage 2
	logic signed [DW-1:0]     dot_s2 [3];
	logic [EW-1:0]            eff_s2;
	logic [FEW-1:0]           fe_s2;

	// stage 3
	logic signed [DW:0]       nd;
	logic [DW-1:0]            ad_s3 [3];
	logic                     neg_s3, far_s3, near_s3;
	logic [EW-1:0]            eff_s3;

	// stage 4
	logic [MW-1:0]            mx_s4, my_s4;
	logic [DW-1:0]            dx_s4, dy_s4;
	logic                     neg_s4, far_s4, near_s4;
	logic [EW-1:0]            eff_s4;

	// stage 5 (output)
	logic [SW-1:0]            e_w, sx, sy;
	logic                     ox, oy;
	logic [sfc_pkg::VERDICT_W-1:0] verdict;
	logic [sfc_pkg::VERDICT_W-1:0] verdict_s5;

	assign en         = ~vld_s5 | out_ready;
	assign item_ready = en;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v[k] = $signed(item_data[k*VW +: VW]);
		end
		r = item_data[3*VW +: C-1];
		for (int k = 0; k < 3; k++) begin
			ax[0][k] = $signed(view_ax[(2-k)*sfc_pkg::AXIS_W +: sfc_pkg::AXIS_W]);
			ax[1][k] = $signed(side_ax[(2-k)*sfc_pkg::AXIS_W +: sfc_pkg::AXIS_W]);
			ax[2][k] = $signed(up_ax[(2-k)*sfc_pkg::AXIS_W +: sfc_pkg::AXIS_W]);
		end
	end

	// valid chain, advances as a whole when the output can move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: per-component axis products and effective radius
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[a][k] <= PW'(v[k]) * PW'(ax[a][k]);
				end
			end
			eff_s1 <= EW'(r) * EW'(sfc_pkg::SQRT3_Q14);
		end
	end

	// stage 2: dot products and far limit
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				dot_s2[a] <= DW'(prod_s1[a][0]) + DW'(prod_s1[a][1]) + DW'(prod_s1[a][2]);
			end
			eff_s2 <= eff_s1;
			fe_s2  <= FEW'({far_dist, AF'(0)}) + FEW'(eff_s1);
		end
	end

	// stage 3: far and near tests, magnitudes
	assign nd = $signed({{(DW+1-(C-1+AF)){1'b0}}, near_dist, AF'(0)})
		- $signed({dot_s2[0][DW-1], dot_s2[0]});

	always_ff @(posedge clk) begin
		if (en) begin
			far_s3  <= dot_s2[0] > $signed({1'b0, fe_s2});
			near_s3 <= dot_s2[0][DW-1] && (nd > $signed({1'b0, eff_s2}));
			neg_s3  <= dot_s2[0][DW-1];
			for (int a = 0; a < 3; a++) begin
				ad_s3[a] <= dot_s2[a][DW-1] ? DW'(-dot_s2[a]) : DW'(dot_s2[a]);
			end
			eff_s3 <= eff_s2;
		end
	end

	// stage 4: cone widths at this depth
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4   <= MW'(tan_x) * MW'(ad_s3[0]);
			my_s4   <= MW'(tan_y) * MW'(ad_s3[0]);
			dx_s4   <= ad_s3[1];
			dy_s4   <= ad_s3[2];
			neg_s4  <= neg_s3;
			far_s4  <= far_s3;
			near_s4 <= near_s3;
			eff_s4  <= eff_s3;
		end
	end

	// stage 5: cone compares and verdict priority
	always_comb begin
		e_w = SW'({eff_s4, TF'(0)});
		if (!neg_s4) begin
			sx = SW'(mx_s4) + e_w;
			sy = SW'(my_s4) + e_w;
		end else begin
			sx = (SW'(mx_s4) > e_w) ? SW'(mx_s4) - e_w : e_w - SW'(mx_s4);
			sy = (SW'(my_s4) > e_w) ? SW'(my_s4) - e_w : e_w - SW'(my_s4);
		end
		ox = SW'({dx_s4, TF'(0)}) > sx;
		oy = SW'({dy_s4, TF'(0)}) > sy;
		if (far_s4)       verdict = sfc_pkg::VERDICT_FAR;
		else if (near_s4) verdict = sfc_pkg::VERDICT_NEAR;
		else if (ox)      verdict = sfc_pkg::VERDICT_HORIZ;
		else if (oy)      verdict = sfc_pkg::VERDICT_VERT;
		else              verdict = sfc_pkg::VERDICT_VISIBLE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			verdict_s5 <= verdict;
		end
	end

	assign out_valid = vld_s5;
	assign out_data  = {4'b0000, verdict_s5, verdict_s5 == sfc_pkg::VERDICT_VISIBLE};

endmodule

`default_nettype wire

@@ rtl/core/sphere_frustum_cull.sv @@
// ----------------------------------------------------------------------------
// sphere_frustum_cull
// View-frustum culling of one bounding sphere per request.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  center_x,y,z, radius
//  m_axis    out  m_axis_tvalid / m_axis_tready  visible, verdict
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One request per cycle sustained while m_axis_tready stays high; a request
// passes the front register, the queue and five test stages. The test
// pipeline moves as a whole while its output register is empty or taken; the
// four-entry queue lets the front keep accepting while it stalls. Reset
// clears all valid state and loads the default camera.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_cull #(
	parameter int COORD_BITS = 20,
	parameter int FRAC_BITS  = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// center_x, center_y, center_z, radius, zero pad
	input  wire logic [((4*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// visible, verdict[2:0], zero pad
	output logic [sfc_pkg::OUT_W-1:0]              m_axis_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int C      = COORD_BITS;
	localparam int IN_W   = ((4*C-1+7)/8)*8;
	localparam int VW     = C + 2;
	localparam int ITEM_W = 3*VW + C - 1;
	localparam int CAMW   = 3*C;
	localparam int AXW    = 3*sfc_pkg::AXIS_W;

	localparam logic [C-2:0] NEAR_RST = (C-1)'(1 << FRAC_BITS);
	localparam logic [C-2:0] FAR_RST  = (C-1)'(1000 << FRAC_BITS);

	logic [CAMW-1:0]              cam_q;
	logic [AXW-1:0]               view_q, side_q, up_q;
	logic [C-2:0]                 near_q, far_q;
	logic [sfc_pkg::TAN_W-1:0]    tanx_q, tany_q;

	logic                         f_valid, f_ready;
	logic [ITEM_W-1:0]            f_data;
	logic                         b_valid, b_ready;
	logic [ITEM_W-1:0]            b_data;
	sfc_pkg::q_stat_t             q_stat;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q  <= '0;
			view_q <= AXW'(48'h4000_0000_0000);
			side_q <= AXW'(48'h0000_C000_0000);
			up_q   <= AXW'(48'h0000_0000_4000);
			near_q <= NEAR_RST;
			far_q  <= FAR_RST;
			tanx_q <= sfc_pkg::TAN_W'(1 << sfc_pkg::TAN_FRAC);
			tany_q <= sfc_pkg::TAN_W'(1 << sfc_pkg::TAN_FRAC);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfc_pkg::REG_CAM_POS: cam_q  <= CAMW'(cfg_data);
				sfc_pkg::REG_VIEW_AX: view_q <= cfg_data[AXW-1:0];
				sfc_pkg::REG_SIDE_AX: side_q <= cfg_data[AXW-1:0];
				sfc_pkg::REG_UP_AX:   up_q   <= cfg_data[AXW-1:0];
				sfc_pkg::REG_NEAR:    near_q <= cfg_data[C-2:0];
				sfc_pkg::REG_FAR:     far_q  <= cfg_data[C-2:0];
				sfc_pkg::REG_TAN_X:   tanx_q <= cfg_data[sfc_pkg::TAN_W-1:0];
				sfc_pkg::REG_TAN_Y:   tany_q <= cfg_data[sfc_pkg::TAN_W-1:0];
				default: ;
			endcase
		end
	end

	sfc_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.IN_W      (IN_W),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.cam_pos   (cam_q),
		.item_valid(f_valid),
		.item_ready(f_ready),
		.item_data (f_data)
	);

	sfc_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_data),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data),
		.stat      (q_stat)
	);

	sfc_back #(
		.COORD_BITS(COORD_BITS),
		.ITEM_W    (ITEM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(b_valid),
		.item_ready(b_ready),
		.item_data (b_data),
		.view_ax   (view_q),
		.side_ax   (side_q),
		.up_ax     (up_q),
		.near_dist (near_q),
		.far_dist  (far_q),
		.tan_x     (tanx_q),
		.tan_y     (tany_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// visible flag agrees with the verdict code
	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == sfc_pkg::VERDICT_VISIBLE)))
		else $error("visible flag disagrees with verdict");

	// an accepted request always lands in the front register
	a_front_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> f_valid)
		else $error("accepted request lost at front");

	// a full queue holds the front item back
	a_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full && f_valid && !b_ready |=> f_valid)
		else $error("front item dropped while queue full");

endmodule

`default_nettype wire
